// ===== rtl/velocity_verlet_particle_update_macros.svh =====
// assertion macros for the velocity verlet particle update block
`ifndef VELOCITY_VERLET_PARTICLE_UPDATE_MACROS_SVH
`define VELOCITY_VERLET_PARTICLE_UPDATE_MACROS_SVH
`ifndef SYNTH
`define VVPU_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("vvpu check failed");
`define VVPU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("vvpu check failed");
`else
`define VVPU_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define VVPU_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== rtl/vvpu_pkg.sv =====
// package: types, constants and helpers of the velocity verlet particle update block
package vvpu_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam logic [31:0] TIME_STEP_RST = 32'd655;
    localparam logic [31:0] SKIN_RST      = 32'd26214;

    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_SKIN      = 1'b1;

    localparam logic OP_KICK_DRIFT = 1'b0;
    localparam logic OP_KICK       = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KMUL,
        S_KDIV,
        S_KADD,
        S_DMUL,
        S_DSQ,
        S_DACC,
        S_MAX,
        S_SQRT,
        S_DRIFT,
        S_DONE
    } t_state;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (x < -66'sd2147483648) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== rtl/velocity_verlet_particle_update.sv =====
// top level: velocity verlet particle update with a shared multiplier and divide/sqrt sequencer
//
// One particle word is taken at a time and o_stall stays high until its result has been
// handed to the output register. Each of the three half kicks of a particle with nonzero mass
// is one 32x32 multiply followed by a restoring divide by twice the mass that yields one
// quotient bit per cycle, and in phase 0 the drift reuses the same multiplier for each axis.
// Zero mass skips the divides. The last particle of a phase-0 pass adds a square root, one
// result bit per cycle. The output register lets the next particle start while a result
// still waits downstream.
`include "velocity_verlet_particle_update_macros.svh"

module velocity_verlet_particle_update
    import vvpu_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    input  logic [31:0] i_mass,
    input  logic        i_last_particle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic signed [31:0] o_new_vel_z,
    output logic [63:0] o_step_sq_dist,
    output logic [63:0] o_pass_max_sq_dist,
    output logic        o_resort_needed,
    output logic        o_mass_error,
    output logic        o_last_result
);

    t_state r_state, n_state;

    logic [31:0] r_time_step, r_skin;
    logic        r_op, r_last;
    logic [31:0] r_mass;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_frc [3];
    logic [1:0]  r_comp;
    logic [5:0]  r_cnt;
    logic [63:0] r_div;
    logic [32:0] r_rem;
    logic [63:0] r_prod, r_dm, r_sq;
    logic [63:0] r_pass_max, r_shown;
    logic [32:0] r_drift;
    logic [63:0] r_sx, r_sr, r_sb;
    logic        r_resort;

    logic        r_out_valid;
    logic signed [31:0] r_out_pos [3];
    logic signed [31:0] r_out_vel [3];
    logic [63:0] r_out_sq, r_out_max;
    logic        r_out_resort, r_out_merr, r_out_last;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] dm_c;
    logic        load_out;
    logic        accept;

    logic [33:0] rem_sh, dsr;
    logic [65:0] q_ext, kick_sum;
    logic [65:0] dp_ext, pos_sum;
    logic [63:0] sq_term;
    logic [64:0] sq_sum;
    logic [63:0] n_max;
    logic [64:0] sq_t;
    logic [33:0] drift_sum;
    logic [32:0] drift_sat;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_mass != 32'd0) n_state = S_KMUL;
                    else if (i_op == OP_KICK_DRIFT) n_state = S_DMUL;
                    else n_state = S_MAX;
                end
            end
            S_KMUL: n_state = S_KDIV;
            S_KDIV: if (r_cnt == 6'd63) n_state = S_KADD;
            S_KADD: begin
                if (r_comp != 2'd2) n_state = S_KMUL;
                else if (r_op == OP_KICK_DRIFT) n_state = S_DMUL;
                else n_state = S_MAX;
            end
            S_DMUL: n_state = S_DSQ;
            S_DSQ:  n_state = S_DACC;
            S_DACC: n_state = (r_comp == 2'd2) ? S_MAX : S_DMUL;
            S_MAX:  n_state = (r_op == OP_KICK_DRIFT && r_last) ? S_SQRT : S_DONE;
            S_SQRT: if (r_cnt == 6'd31) n_state = S_DRIFT;
            S_DRIFT: n_state = S_DONE;
            S_DONE: if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall  = (r_state != S_IDLE);
        accept   = (r_state == S_IDLE) && i_valid;
        load_out = (r_state == S_DONE) && !(r_out_valid && i_stall);
        mul_a    = r_time_step;
        mul_b    = mag32(r_frc[r_comp]);
        unique case (r_state)
            S_DMUL: begin
                mul_a = mag32(r_vel[r_comp]);
                mul_b = r_time_step;
            end
            S_DSQ: begin
                mul_a = dm_c[31:0];
                mul_b = dm_c[31:0];
            end
            default: begin
            end
        endcase
    end

    // shared datapath
    always_comb begin
        dm_c      = r_prod >> FRAC_BITS;
        mul_p     = 64'(mul_a) * 64'(mul_b);
        rem_sh    = {r_rem, r_div[63]};
        dsr       = {r_mass, 2'b00} >> 1;
        q_ext     = {2'b00, r_div};
        kick_sum  = 66'(r_vel[r_comp]) + (r_frc[r_comp][31] ? (66'd0 - q_ext) : q_ext);
        dp_ext    = {2'b00, r_dm};
        pos_sum   = 66'(r_pos[r_comp]) + (r_vel[r_comp][31] ? (66'd0 - dp_ext) : dp_ext);
        sq_term   = (r_dm[63:32] != 32'd0) ? {64{1'b1}} : r_prod;
        sq_sum    = 65'(r_sq) + 65'(sq_term);
        n_max     = (r_op == OP_KICK_DRIFT && r_sq > r_pass_max) ? r_sq : r_pass_max;
        sq_t      = 65'(r_sr) + 65'(r_sb);
        drift_sum = 34'(r_drift) + 34'(r_sr[31:0]);
        drift_sat = drift_sum[33] ? {33{1'b1}} : drift_sum[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time_step <= TIME_STEP_RST;
            r_skin      <= SKIN_RST;
            r_pass_max  <= 64'd0;
            r_drift     <= 33'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TIME_STEP: r_time_step <= i_cfg_data;
                    REG_SKIN:      r_skin      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (load_out) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_MAX: r_pass_max <= n_max;
                S_DRIFT: begin
                    r_pass_max <= 64'd0;
                    if ({drift_sat, 1'b0} > 34'(r_skin)) r_drift <= 33'd0;
                    else r_drift <= drift_sat;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op     <= i_op;
                r_last   <= i_last_particle;
                r_mass   <= i_mass;
                r_pos[0] <= i_pos_x;
                r_pos[1] <= i_pos_y;
                r_pos[2] <= i_pos_z;
                r_vel[0] <= i_vel_x;
                r_vel[1] <= i_vel_y;
                r_vel[2] <= i_vel_z;
                r_frc[0] <= i_force_x;
                r_frc[1] <= i_force_y;
                r_frc[2] <= i_force_z;
                r_comp   <= 2'd0;
                r_sq     <= 64'd0;
                r_resort <= 1'b0;
            end
            S_KMUL: begin
                r_div <= mul_p;
                r_rem <= 33'd0;
                r_cnt <= 6'd0;
            end
            S_KDIV: begin
                r_cnt <= r_cnt + 6'd1;
                if (rem_sh >= dsr) begin
                    r_rem <= 33'(rem_sh - dsr);
                    r_div <= {r_div[62:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[32:0];
                    r_div <= {r_div[62:0], 1'b0};
                end
            end
            S_KADD: begin
                r_vel[r_comp] <= sat32(kick_sum);
                r_comp        <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
            end
            S_DMUL: r_prod <= mul_p;
            S_DSQ: begin
                r_dm   <= dm_c;
                r_prod <= mul_p;
            end
            S_DACC: begin
                r_pos[r_comp] <= sat32(pos_sum);
                r_sq          <= sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
                r_comp        <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
            end
            S_MAX: begin
                r_shown <= n_max;
                r_sx    <= n_max;
                r_sr    <= 64'd0;
                r_sb    <= 64'h4000_0000_0000_0000;
                r_cnt   <= 6'd0;
            end
            S_SQRT: begin
                r_cnt <= r_cnt + 6'd1;
                r_sb  <= r_sb >> 2;
                if (65'(r_sx) >= sq_t) begin
                    r_sx <= 64'(65'(r_sx) - sq_t);
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
            end
            S_DRIFT: r_resort <= ({drift_sat, 1'b0} > 34'(r_skin));
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_pos    <= r_pos;
            r_out_vel    <= r_vel;
            r_out_sq     <= r_sq;
            r_out_max    <= r_shown;
            r_out_resort <= r_resort;
            r_out_merr   <= (r_mass == 32'd0);
            r_out_last   <= r_last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_new_pos_x        = r_out_pos[0];
    assign o_new_pos_y        = r_out_pos[1];
    assign o_new_pos_z        = r_out_pos[2];
    assign o_new_vel_x        = r_out_vel[0];
    assign o_new_vel_y        = r_out_vel[1];
    assign o_new_vel_z        = r_out_vel[2];
    assign o_step_sq_dist     = r_out_sq;
    assign o_pass_max_sq_dist = r_out_max;
    assign o_resort_needed    = r_out_resort;
    assign o_mass_error       = r_out_merr;
    assign o_last_result      = r_out_last;

    `VVPU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `VVPU_ASSERT_NEXT(a_pass_max_clear, i_clk, i_rst_n, r_state == S_DRIFT, r_pass_max == 64'd0)
    `VVPU_ASSERT_SAME(a_resort_at_end, i_clk, i_rst_n, r_out_valid && r_out_resort, r_out_last)
    `VVPU_ASSERT_SAME(a_max_covers_step, i_clk, i_rst_n, r_out_valid, r_out_max >= r_out_sq)

endmodule
